>>> sv/icep_pkg.sv
// ----------------------------------------------------------------------------
// icep_pkg
// types, codes and tables shared by the isdn call endpoint state machine
// ----------------------------------------------------------------------------
`default_nettype none

package icep_pkg;

    typedef enum logic [2:0] {
        ST_NULL = 3'd0,
        ST_RCVD = 3'd1,
        ST_CONN = 3'd2,
        ST_PROC = 3'd3,
        ST_RELR = 3'd4,
        ST_OVLP = 3'd5
    } state_t;

    // event codes
    localparam logic [4:0] EV_ALERT_REQ   = 5'd0;
    localparam logic [4:0] EV_CONN_REQ    = 5'd1;
    localparam logic [4:0] EV_PROC_REQ    = 5'd2;
    localparam logic [4:0] EV_SETUPACK_REQ = 5'd3;
    localparam logic [4:0] EV_REL_REQ     = 5'd4;
    localparam logic [4:0] EV_INFO_REQ    = 5'd5;
    localparam logic [4:0] EV_ENQ_REQ     = 5'd6;
    localparam logic [4:0] EV_DL_ESTAB    = 5'd7;
    localparam logic [4:0] EV_DL_REL      = 5'd8;
    localparam logic [4:0] EV_RX_ALERT    = 5'd9;
    localparam logic [4:0] EV_RX_PROC     = 5'd10;
    localparam logic [4:0] EV_RX_CONN     = 5'd11;
    localparam logic [4:0] EV_RX_PROGRESS = 5'd12;
    localparam logic [4:0] EV_RX_DISC     = 5'd13;
    localparam logic [4:0] EV_RX_REL      = 5'd14;
    localparam logic [4:0] EV_RX_RELCOMP  = 5'd15;
    localparam logic [4:0] EV_RX_STATUS   = 5'd16;
    localparam logic [4:0] EV_RX_INFO     = 5'd17;
    localparam logic [4:0] EV_RX_ENQ      = 5'd18;
    localparam logic [4:0] EV_RX_OTHER    = 5'd20;
    localparam logic [4:0] EV_T304        = 5'd22;
    localparam logic [4:0] EV_T308        = 5'd23;
    localparam logic [4:0] EV_T322        = 5'd24;

    // messages sent
    localparam logic [2:0] MSG_NONE    = 3'd0;
    localparam logic [2:0] MSG_REL     = 3'd1;
    localparam logic [2:0] MSG_RELCOMP = 3'd2;
    localparam logic [2:0] MSG_STATUS  = 3'd3;
    localparam logic [2:0] MSG_ENQ     = 3'd4;
    localparam logic [2:0] MSG_INFO    = 3'd5;

    // upper layer indications
    localparam logic [3:0] IND_NONE       = 4'd0;
    localparam logic [3:0] IND_ALERT      = 4'd1;
    localparam logic [3:0] IND_PROC       = 4'd2;
    localparam logic [3:0] IND_CONN       = 4'd3;
    localparam logic [3:0] IND_PROGRESS   = 4'd4;
    localparam logic [3:0] IND_INFO       = 4'd5;
    localparam logic [3:0] IND_REL        = 4'd6;
    localparam logic [3:0] IND_RELCOMP    = 4'd7;
    localparam logic [3:0] IND_REL_RELCOMP = 4'd8;
    localparam logic [3:0] IND_STATUS_ERR = 4'd9;

    // timer mask bits
    localparam logic [2:0] TM_NONE = 3'b000;
    localparam logic [2:0] TM_T304 = 3'b001;
    localparam logic [2:0] TM_T308 = 3'b010;
    localparam logic [2:0] TM_T322 = 3'b100;
    localparam logic [2:0] TM_ALL  = 3'b111;

    // causes
    localparam logic [6:0] CAUSE_NONE       = 7'd0;
    localparam logic [6:0] CAUSE_RESP_ENQ   = 7'd30;
    localparam logic [6:0] CAUSE_TEMP_FAIL  = 7'd41;
    localparam logic [6:0] CAUSE_NOT_IMPL   = 7'd97;
    localparam logic [6:0] CAUSE_NOT_COMPAT = 7'd101;
    localparam logic [6:0] CAUSE_TIMER      = 7'd102;

    localparam logic [2:0] ENQ_COUNT_MAX     = 3'd7;
    localparam logic [2:0] MAX_ENQ_RESET     = 3'd3;

    typedef struct packed {
        logic [4:0] req_type;
        logic       decode_ok;
        logic       has_call_state;
        logic [5:0] call_state_value;
        logic       has_cause;
        logic [6:0] cause_value;
        logic [7:0] msg_type_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] next_state;
        logic [2:0] send_msg;
        logic [6:0] send_cause;
        logic [7:0] diag_byte;
        logic [5:0] reported_state;
        logic [3:0] indication;
        logic [2:0] timer_start;
        logic [2:0] timer_stop;
        logic       unexpected;
    } out_item_t;

    typedef struct packed {
        state_t     call_state;
        logic [2:0] timers_running;
        logic       release_retried;
        logic [2:0] enquiry_count;
    } ctx_t;

    // call state number carried in the call state element
    function automatic logic [5:0] ie_of(input state_t s);
        logic [5:0] v;
        case (s)
            ST_NULL: v = 6'd0;
            ST_RCVD: v = 6'd7;
            ST_CONN: v = 6'd8;
            ST_PROC: v = 6'd9;
            ST_RELR: v = 6'd19;
            ST_OVLP: v = 6'd25;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/icep_if.sv
// ----------------------------------------------------------------------------
// icep_if
// valid/ready channels of the isdn call endpoint state machine
// ----------------------------------------------------------------------------
`default_nettype none

interface icep_in_if;
    logic               valid;
    logic               ready;
    icep_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface icep_out_if;
    logic                valid;
    logic                ready;
    icep_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface icep_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/icep_decide.sv
// ----------------------------------------------------------------------------
// icep_decide
// transition and action logic for one event against the current call context
// ----------------------------------------------------------------------------
`default_nettype none

module icep_decide (
    input  wire icep_pkg::in_item_t  item,
    input  wire icep_pkg::ctx_t      ctx,
    input  wire logic [2:0]          max_enquiries,
    output icep_pkg::out_item_t      act,
    output icep_pkg::ctx_t           ctx_next
);

    always_comb
    begin
        icep_pkg::state_t s;
        icep_pkg::state_t nxt;
        logic [2:0] run;
        logic [2:0] newrun;
        logic [2:0] msg;
        logic [6:0] cause;
        logic [7:0] diag;
        logic [5:0] rep;
        logic [3:0] ind;
        logic [2:0] start;
        logic [2:0] stop;
        logic       unexp;
        logic       retried;
        logic [2:0] enq;
        logic       ok;
        logic       skip;
        logic       not_compat;

        s       = ctx.call_state;
        nxt     = s;
        run     = ctx.timers_running;
        msg     = icep_pkg::MSG_NONE;
        cause   = icep_pkg::CAUSE_NONE;
        diag    = 8'd0;
        rep     = 6'd0;
        ind     = icep_pkg::IND_NONE;
        start   = icep_pkg::TM_NONE;
        stop    = icep_pkg::TM_NONE;
        unexp   = 1'b0;
        retried = ctx.release_retried;
        enq     = ctx.enquiry_count;
        ok      = item.decode_ok;
        skip    = 1'b0;
        not_compat = 1'b0;

        // an expiry clears its own running bit
        if (item.req_type == icep_pkg::EV_T304) run = run & ~icep_pkg::TM_T304;
        if (item.req_type == icep_pkg::EV_T308) run = run & ~icep_pkg::TM_T308;
        if (item.req_type == icep_pkg::EV_T322) run = run & ~icep_pkg::TM_T322;

        case (item.req_type)
            icep_pkg::EV_ALERT_REQ, icep_pkg::EV_CONN_REQ,
            icep_pkg::EV_PROC_REQ, icep_pkg::EV_SETUPACK_REQ:
            begin
                if (s != icep_pkg::ST_NULL)
                    unexp = 1'b1;
                else if (item.req_type == icep_pkg::EV_ALERT_REQ)
                    nxt = icep_pkg::ST_RCVD;
                else if (item.req_type == icep_pkg::EV_CONN_REQ)
                    nxt = icep_pkg::ST_CONN;
                else if (item.req_type == icep_pkg::EV_PROC_REQ)
                    nxt = icep_pkg::ST_PROC;
                else
                begin
                    start = start | icep_pkg::TM_T304;
                    nxt   = icep_pkg::ST_OVLP;
                end
            end
            icep_pkg::EV_REL_REQ:
            begin
                if (s == icep_pkg::ST_RELR)
                    unexp = 1'b1;
                else
                begin
                    if (s == icep_pkg::ST_OVLP) stop = stop | icep_pkg::TM_T304;
                    msg   = icep_pkg::MSG_REL;
                    cause = icep_pkg::CAUSE_NONE;
                    start = start | icep_pkg::TM_T308;
                    nxt   = icep_pkg::ST_RELR;
                end
            end
            icep_pkg::EV_INFO_REQ:
            begin
                if (s == icep_pkg::ST_RCVD || s == icep_pkg::ST_CONN ||
                    s == icep_pkg::ST_PROC)
                    msg = icep_pkg::MSG_INFO;
                else if (s == icep_pkg::ST_OVLP)
                begin
                    msg   = icep_pkg::MSG_INFO;
                    stop  = stop | icep_pkg::TM_T304;
                    start = start | icep_pkg::TM_T304;
                end
                else
                    unexp = 1'b1;
            end
            icep_pkg::EV_ENQ_REQ:
            begin
                if (s == icep_pkg::ST_NULL)
                    unexp = 1'b1;
                else if ((run & icep_pkg::TM_T322) == icep_pkg::TM_NONE)
                begin
                    msg   = icep_pkg::MSG_ENQ;
                    start = start | icep_pkg::TM_T322;
                    enq   = 3'd0;
                end
            end
            icep_pkg::EV_DL_ESTAB:
            begin
                if (s == icep_pkg::ST_OVLP)
                begin
                    stop  = stop | icep_pkg::TM_T304;
                    msg   = icep_pkg::MSG_REL;
                    cause = icep_pkg::CAUSE_TEMP_FAIL;
                    start = start | icep_pkg::TM_T308;
                    nxt   = icep_pkg::ST_RELR;
                    ind   = icep_pkg::IND_REL;
                end
            end
            icep_pkg::EV_DL_REL:
            begin
                if (s != icep_pkg::ST_NULL)
                begin
                    stop = stop | icep_pkg::TM_ALL;
                    ind  = icep_pkg::IND_REL_RELCOMP;
                    nxt  = icep_pkg::ST_NULL;
                end
            end
            icep_pkg::EV_RX_ALERT:
            begin
                if (s == icep_pkg::ST_PROC || s == icep_pkg::ST_OVLP)
                begin
                    if (ok)
                    begin
                        if (s == icep_pkg::ST_OVLP) stop = stop | icep_pkg::TM_T304;
                        nxt = icep_pkg::ST_RCVD;
                        ind = icep_pkg::IND_ALERT;
                    end
                end
                else
                    not_compat = 1'b1;
            end
            icep_pkg::EV_RX_PROC:
            begin
                if (s == icep_pkg::ST_OVLP)
                begin
                    if (ok)
                    begin
                        stop = stop | icep_pkg::TM_T304;
                        nxt  = icep_pkg::ST_PROC;
                        ind  = icep_pkg::IND_PROC;
                    end
                end
                else
                    not_compat = 1'b1;
            end
            icep_pkg::EV_RX_CONN, icep_pkg::EV_RX_PROGRESS:
            begin
                if (s == icep_pkg::ST_RCVD || s == icep_pkg::ST_PROC ||
                    s == icep_pkg::ST_OVLP)
                begin
                    if (ok)
                    begin
                        if (s == icep_pkg::ST_OVLP) stop = stop | icep_pkg::TM_T304;
                        if (item.req_type == icep_pkg::EV_RX_CONN)
                        begin
                            nxt = icep_pkg::ST_CONN;
                            ind = icep_pkg::IND_CONN;
                        end
                        else
                            ind = icep_pkg::IND_PROGRESS;
                    end
                end
                else
                    not_compat = 1'b1;
            end
            icep_pkg::EV_RX_DISC:
            begin
                if (s == icep_pkg::ST_NULL)
                    not_compat = 1'b1;
                else if (s != icep_pkg::ST_RELR && ok)
                begin
                    if (s == icep_pkg::ST_OVLP) stop = stop | icep_pkg::TM_T304;
                    msg   = icep_pkg::MSG_REL;
                    cause = icep_pkg::CAUSE_NONE;
                    start = start | icep_pkg::TM_T308;
                    nxt   = icep_pkg::ST_RELR;
                    ind   = icep_pkg::IND_REL;
                end
            end
            icep_pkg::EV_RX_REL, icep_pkg::EV_RX_RELCOMP:
            begin
                if (s == icep_pkg::ST_NULL)
                    not_compat = 1'b1;
                else if (ok)
                begin
                    if (s == icep_pkg::ST_RELR)
                    begin
                        stop = stop | icep_pkg::TM_T308;
                        ind  = icep_pkg::IND_RELCOMP;
                    end
                    else
                    begin
                        if (s == icep_pkg::ST_OVLP) stop = stop | icep_pkg::TM_T304;
                        if (item.req_type == icep_pkg::EV_RX_REL)
                            msg = icep_pkg::MSG_RELCOMP;
                        ind = icep_pkg::IND_REL_RELCOMP;
                    end
                    nxt = icep_pkg::ST_NULL;
                end
            end
            icep_pkg::EV_RX_STATUS:
            begin
                if (s == icep_pkg::ST_NULL)
                    not_compat = 1'b1;
                else if (ok)
                begin
                    if (s == icep_pkg::ST_RELR)
                    begin
                        if (item.has_call_state && item.call_state_value == 6'd0)
                        begin
                            stop = stop | icep_pkg::TM_T308;
                            ind  = icep_pkg::IND_RELCOMP;
                            nxt  = icep_pkg::ST_NULL;
                        end
                    end
                    else
                    begin
                        // enquiry answered: not implemented ends handling, response to enquiry stops t322
                        if ((run & icep_pkg::TM_T322) != icep_pkg::TM_NONE && item.has_cause)
                        begin
                            if (item.cause_value == icep_pkg::CAUSE_NOT_IMPL)
                                skip = 1'b1;
                            else if (item.cause_value == icep_pkg::CAUSE_RESP_ENQ)
                                stop = stop | icep_pkg::TM_T322;
                        end
                        if (!skip)
                        begin
                            if (item.has_call_state && item.call_state_value == 6'd0)
                            begin
                                stop = stop | icep_pkg::TM_ALL;
                                ind  = icep_pkg::IND_REL_RELCOMP;
                                nxt  = icep_pkg::ST_NULL;
                            end
                            else if (!(item.has_call_state &&
                                       item.call_state_value == icep_pkg::ie_of(s)))
                            begin
                                stop  = stop | icep_pkg::TM_ALL;
                                msg   = icep_pkg::MSG_REL;
                                cause = icep_pkg::CAUSE_NOT_COMPAT;
                                start = start | icep_pkg::TM_T308;
                                nxt   = icep_pkg::ST_RELR;
                                ind   = icep_pkg::IND_STATUS_ERR;
                            end
                        end
                    end
                end
            end
            icep_pkg::EV_RX_INFO:
            begin
                if (s == icep_pkg::ST_NULL)
                    not_compat = 1'b1;
                else if ((s == icep_pkg::ST_RCVD || s == icep_pkg::ST_CONN ||
                          s == icep_pkg::ST_PROC) && ok)
                    ind = icep_pkg::IND_INFO;
            end
            icep_pkg::EV_RX_ENQ:
            begin
                msg   = icep_pkg::MSG_STATUS;
                cause = icep_pkg::CAUSE_RESP_ENQ;
                rep   = icep_pkg::ie_of(s);
            end
            icep_pkg::EV_RX_OTHER:
            begin
                not_compat = 1'b1;
            end
            icep_pkg::EV_T304:
            begin
                if (s != icep_pkg::ST_OVLP)
                    unexp = 1'b1;
                else
                begin
                    msg   = icep_pkg::MSG_REL;
                    cause = icep_pkg::CAUSE_TIMER;
                    start = start | icep_pkg::TM_T308;
                    nxt   = icep_pkg::ST_RELR;
                    ind   = icep_pkg::IND_REL;
                end
            end
            icep_pkg::EV_T308:
            begin
                if (s != icep_pkg::ST_RELR)
                    unexp = 1'b1;
                else if (!ctx.release_retried)
                begin
                    msg     = icep_pkg::MSG_REL;
                    start   = start | icep_pkg::TM_T308;
                    retried = 1'b1;
                end
                else
                begin
                    ind = icep_pkg::IND_RELCOMP;
                    nxt = icep_pkg::ST_NULL;
                end
            end
            icep_pkg::EV_T322:
            begin
                if (s == icep_pkg::ST_NULL)
                    unexp = 1'b1;
                else if (ctx.enquiry_count > max_enquiries)
                begin
                    msg   = icep_pkg::MSG_REL;
                    cause = icep_pkg::CAUSE_TEMP_FAIL;
                    start = start | icep_pkg::TM_T308;
                    nxt   = icep_pkg::ST_RELR;
                    ind   = icep_pkg::IND_REL;
                end
                else
                begin
                    msg   = icep_pkg::MSG_ENQ;
                    start = start | icep_pkg::TM_T322;
                    if (ctx.enquiry_count < icep_pkg::ENQ_COUNT_MAX)
                        enq = ctx.enquiry_count + 3'd1;
                end
            end
            default:
            begin
                unexp = 1'b0;
            end
        endcase

        // message not compatible with the call state
        if (not_compat)
        begin
            unexp = 1'b1;
            if (s != icep_pkg::ST_NULL)
            begin
                msg   = icep_pkg::MSG_STATUS;
                cause = icep_pkg::CAUSE_NOT_COMPAT;
                diag  = item.msg_type_byte;
                rep   = icep_pkg::ie_of(s);
            end
        end

        newrun = (run & ~stop) | start;

        // back to null: everything stops and the counters clear
        if (nxt == icep_pkg::ST_NULL)
        begin
            stop    = stop | run | start;
            start   = icep_pkg::TM_NONE;
            newrun  = icep_pkg::TM_NONE;
            retried = 1'b0;
            enq     = 3'd0;
        end

        act.next_state     = nxt;
        act.send_msg       = msg;
        act.send_cause     = cause;
        act.diag_byte      = diag;
        act.reported_state = rep;
        act.indication     = ind;
        act.timer_start    = start;
        act.timer_stop     = stop;
        act.unexpected     = unexp;

        ctx_next.call_state      = nxt;
        ctx_next.timers_running  = newrun;
        ctx_next.release_retried = retried;
        ctx_next.enquiry_count   = enq;
    end

endmodule

`default_nettype wire

>>> sv/isdn_call_endpoint_fsm.sv
// ----------------------------------------------------------------------------
// isdn_call_endpoint_fsm
// network side layer 3 call control for one isdn endpoint
// ----------------------------------------------------------------------------
// One event item in, one action item out. An accepted item is held in an
// input register; once the output register is empty or being read, the
// decision logic applies it to the call context (state, running timers,
// release retry flag, enquiry count) and the action lands in the output
// register, where the result is offered until it is taken. One item is
// taken every cycle while the output is not stalled: the context feedback
// loop is a single combinational pass from the context registers back to
// themselves. The input takes a new item while a result waits as long as
// the input register is free. The configuration channel is always ready;
// write max_enquiries only while no item is in flight.
`default_nettype none

module isdn_call_endpoint_fsm (
    input  wire logic    clk,
    input  wire logic    rst_n,
    icep_in_if.sink      in_ch,
    icep_out_if.source   out_ch,
    icep_cfg_if.sink     cfg
);

    icep_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    icep_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;
    icep_pkg::ctx_t      ctx_reg;
    icep_pkg::ctx_t      ctx_next;
    icep_pkg::out_item_t act;
    logic [2:0]          max_enq_reg;
    logic                advance;

    // item moves from the input register into the output register
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;
    assign cfg.ready    = 1'b1;

    icep_decide u_decide (
        .item          (in_item_reg),
        .ctx           (ctx_reg),
        .max_enquiries (max_enq_reg),
        .act           (act),
        .ctx_next      (ctx_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
            ctx_reg.call_state          <= icep_pkg::ST_NULL;
            ctx_reg.timers_running      <= icep_pkg::TM_NONE;
            ctx_reg.release_retried     <= 1'b0;
            ctx_reg.enquiry_count       <= 3'd0;
            max_enq_reg                 <= icep_pkg::MAX_ENQ_RESET;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
                max_enq_reg <= cfg.data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            in_item_reg <= in_ch.data;
        if (advance)
            out_item_reg <= act;
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// call endpoint state machine: event items in, action items checked out
// ----------------------------------------------------------------------------
// Event items are sent with random gaps and checked against an in-bench copy
// of the call control rules. The result side stalls at random and once holds
// off for a long stretch so that the block fills and stalls its input.
// Directed events come first, then random calls under several enquiry
// limits, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic [4:0] EV_RX_SETUP     = 5'd19;
    localparam logic [4:0] EV_RX_UNKNOWN   = 5'd21;
    localparam logic [4:0] EV_UNUSED_HIGH  = 5'd31;
    localparam int         LONG_HOLD       = 300;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         GAP_MAX         = 17;

    logic clk;
    logic rst_n;

    icep_in_if  in_ch ();
    icep_out_if out_ch ();
    icep_cfg_if cfg_ch ();

    isdn_call_endpoint_fsm u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // call context as the bench expects it
    icep_pkg::state_t model_state;
    logic [2:0]       model_timers;
    logic             model_retried;
    logic [2:0]       model_enq_count;
    logic [2:0]       model_max_enq;

    icep_pkg::out_item_t expected_actions[$];
    int        errors;
    int        idle_cycles;
    int        send_gap_max;
    int        recv_gap_max;
    bit        hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [5:0] state_number(icep_pkg::state_t s);
        case (s)
            icep_pkg::ST_RCVD: return 6'd7;
            icep_pkg::ST_CONN: return 6'd8;
            icep_pkg::ST_PROC: return 6'd9;
            icep_pkg::ST_RELR: return 6'd19;
            icep_pkg::ST_OVLP: return 6'd25;
            default: return 6'd0;
        endcase
    endfunction

    function automatic icep_pkg::out_item_t with_release(icep_pkg::out_item_t a,
                                                         logic [6:0] cause);
        a.send_msg = icep_pkg::MSG_REL;
        a.send_cause = cause;
        a.timer_start = a.timer_start | icep_pkg::TM_T308;
        a.next_state = icep_pkg::ST_RELR;
        return a;
    endfunction

    function automatic icep_pkg::out_item_t with_not_compat(icep_pkg::out_item_t a,
                                                            icep_pkg::state_t s,
                                                            logic [7:0] mt);
        a.unexpected = 1'b1;
        if (s != icep_pkg::ST_NULL)
        begin
            a.send_msg = icep_pkg::MSG_STATUS;
            a.send_cause = icep_pkg::CAUSE_NOT_COMPAT;
            a.diag_byte = mt;
            a.reported_state = state_number(s);
        end
        return a;
    endfunction

    // applies one event to the bench context and returns the action expected
    function automatic icep_pkg::out_item_t predict_action(icep_pkg::in_item_t ev);
        icep_pkg::out_item_t a;
        icep_pkg::state_t    s;
        logic [2:0] run;
        logic [2:0] newrun;
        logic       skip;
        a = '0;
        s = model_state;
        run = model_timers;
        skip = 1'b0;
        a.next_state = s;
        case (ev.req_type)
            icep_pkg::EV_T304: run = run & ~icep_pkg::TM_T304;
            icep_pkg::EV_T308: run = run & ~icep_pkg::TM_T308;
            icep_pkg::EV_T322: run = run & ~icep_pkg::TM_T322;
            default: ;
        endcase
        case (ev.req_type)
            icep_pkg::EV_ALERT_REQ, icep_pkg::EV_CONN_REQ, icep_pkg::EV_PROC_REQ,
            icep_pkg::EV_SETUPACK_REQ:
            begin
                if (s != icep_pkg::ST_NULL)
                    a.unexpected = 1'b1;
                else if (ev.req_type == icep_pkg::EV_ALERT_REQ)
                    a.next_state = icep_pkg::ST_RCVD;
                else if (ev.req_type == icep_pkg::EV_CONN_REQ)
                    a.next_state = icep_pkg::ST_CONN;
                else if (ev.req_type == icep_pkg::EV_PROC_REQ)
                    a.next_state = icep_pkg::ST_PROC;
                else
                begin
                    a.timer_start = a.timer_start | icep_pkg::TM_T304;
                    a.next_state = icep_pkg::ST_OVLP;
                end
            end
            icep_pkg::EV_REL_REQ:
            begin
                if (s == icep_pkg::ST_RELR)
                    a.unexpected = 1'b1;
                else
                begin
                    if (s == icep_pkg::ST_OVLP)
                        a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                    a = with_release(a, icep_pkg::CAUSE_NONE);
                end
            end
            icep_pkg::EV_INFO_REQ:
            begin
                if (s == icep_pkg::ST_RCVD || s == icep_pkg::ST_CONN
                    || s == icep_pkg::ST_PROC)
                    a.send_msg = icep_pkg::MSG_INFO;
                else if (s == icep_pkg::ST_OVLP)
                begin
                    a.send_msg = icep_pkg::MSG_INFO;
                    a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                    a.timer_start = a.timer_start | icep_pkg::TM_T304;
                end
                else
                    a.unexpected = 1'b1;
            end
            icep_pkg::EV_ENQ_REQ:
            begin
                if (s == icep_pkg::ST_NULL)
                    a.unexpected = 1'b1;
                else if ((run & icep_pkg::TM_T322) == icep_pkg::TM_NONE)
                begin
                    a.send_msg = icep_pkg::MSG_ENQ;
                    a.timer_start = a.timer_start | icep_pkg::TM_T322;
                    model_enq_count = 3'd0;
                end
            end
            icep_pkg::EV_DL_ESTAB:
            begin
                if (s == icep_pkg::ST_OVLP)
                begin
                    a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                    a = with_release(a, icep_pkg::CAUSE_TEMP_FAIL);
                    a.indication = icep_pkg::IND_REL;
                end
            end
            icep_pkg::EV_DL_REL:
            begin
                if (s != icep_pkg::ST_NULL)
                begin
                    a.timer_stop = a.timer_stop | icep_pkg::TM_ALL;
                    a.indication = icep_pkg::IND_REL_RELCOMP;
                    a.next_state = icep_pkg::ST_NULL;
                end
            end
            icep_pkg::EV_RX_ALERT:
            begin
                if (s == icep_pkg::ST_PROC || s == icep_pkg::ST_OVLP)
                begin
                    if (ev.decode_ok)
                    begin
                        if (s == icep_pkg::ST_OVLP)
                            a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                        a.next_state = icep_pkg::ST_RCVD;
                        a.indication = icep_pkg::IND_ALERT;
                    end
                end
                else
                    a = with_not_compat(a, s, ev.msg_type_byte);
            end
            icep_pkg::EV_RX_PROC:
            begin
                if (s == icep_pkg::ST_OVLP)
                begin
                    if (ev.decode_ok)
                    begin
                        a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                        a.next_state = icep_pkg::ST_PROC;
                        a.indication = icep_pkg::IND_PROC;
                    end
                end
                else
                    a = with_not_compat(a, s, ev.msg_type_byte);
            end
            icep_pkg::EV_RX_CONN, icep_pkg::EV_RX_PROGRESS:
            begin
                if (s == icep_pkg::ST_RCVD || s == icep_pkg::ST_PROC
                    || s == icep_pkg::ST_OVLP)
                begin
                    if (ev.decode_ok)
                    begin
                        if (s == icep_pkg::ST_OVLP)
                            a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                        if (ev.req_type == icep_pkg::EV_RX_CONN)
                        begin
                            a.next_state = icep_pkg::ST_CONN;
                            a.indication = icep_pkg::IND_CONN;
                        end
                        else
                            a.indication = icep_pkg::IND_PROGRESS;
                    end
                end
                else
                    a = with_not_compat(a, s, ev.msg_type_byte);
            end
            icep_pkg::EV_RX_DISC:
            begin
                if (s == icep_pkg::ST_NULL)
                    a = with_not_compat(a, s, ev.msg_type_byte);
                else if (s != icep_pkg::ST_RELR && ev.decode_ok)
                begin
                    if (s == icep_pkg::ST_OVLP)
                        a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                    a = with_release(a, icep_pkg::CAUSE_NONE);
                    a.indication = icep_pkg::IND_REL;
                end
            end
            icep_pkg::EV_RX_REL, icep_pkg::EV_RX_RELCOMP:
            begin
                if (s == icep_pkg::ST_NULL)
                    a = with_not_compat(a, s, ev.msg_type_byte);
                else if (ev.decode_ok)
                begin
                    if (s == icep_pkg::ST_RELR)
                    begin
                        a.timer_stop = a.timer_stop | icep_pkg::TM_T308;
                        a.indication = icep_pkg::IND_RELCOMP;
                    end
                    else
                    begin
                        if (s == icep_pkg::ST_OVLP)
                            a.timer_stop = a.timer_stop | icep_pkg::TM_T304;
                        if (ev.req_type == icep_pkg::EV_RX_REL)
                            a.send_msg = icep_pkg::MSG_RELCOMP;
                        a.indication = icep_pkg::IND_REL_RELCOMP;
                    end
                    a.next_state = icep_pkg::ST_NULL;
                end
            end
            icep_pkg::EV_RX_STATUS:
            begin
                if (s == icep_pkg::ST_NULL)
                    a = with_not_compat(a, s, ev.msg_type_byte);
                else if (ev.decode_ok && s == icep_pkg::ST_RELR)
                begin
                    if (ev.has_call_state && ev.call_state_value == 6'd0)
                    begin
                        a.timer_stop = a.timer_stop | icep_pkg::TM_T308;
                        a.indication = icep_pkg::IND_RELCOMP;
                        a.next_state = icep_pkg::ST_NULL;
                    end
                end
                else if (ev.decode_ok)
                begin
                    if ((run & icep_pkg::TM_T322) != icep_pkg::TM_NONE && ev.has_cause)
                    begin
                        if (ev.cause_value == icep_pkg::CAUSE_NOT_IMPL)
                            skip = 1'b1;
                        else if (ev.cause_value == icep_pkg::CAUSE_RESP_ENQ)
                            a.timer_stop = a.timer_stop | icep_pkg::TM_T322;
                    end
                    if (!skip)
                    begin
                        if (ev.has_call_state && ev.call_state_value == 6'd0)
                        begin
                            a.timer_stop = a.timer_stop | icep_pkg::TM_ALL;
                            a.indication = icep_pkg::IND_REL_RELCOMP;
                            a.next_state = icep_pkg::ST_NULL;
                        end
                        else if (!(ev.has_call_state
                                   && ev.call_state_value == state_number(s)))
                        begin
                            a.timer_stop = a.timer_stop | icep_pkg::TM_ALL;
                            a = with_release(a, icep_pkg::CAUSE_NOT_COMPAT);
                            a.indication = icep_pkg::IND_STATUS_ERR;
                        end
                    end
                end
            end
            icep_pkg::EV_RX_INFO:
            begin
                if (s == icep_pkg::ST_NULL)
                    a = with_not_compat(a, s, ev.msg_type_byte);
                else if ((s == icep_pkg::ST_RCVD || s == icep_pkg::ST_CONN
                          || s == icep_pkg::ST_PROC) && ev.decode_ok)
                    a.indication = icep_pkg::IND_INFO;
            end
            icep_pkg::EV_RX_ENQ:
            begin
                a.send_msg = icep_pkg::MSG_STATUS;
                a.send_cause = icep_pkg::CAUSE_RESP_ENQ;
                a.reported_state = state_number(s);
            end
            icep_pkg::EV_RX_OTHER:
                a = with_not_compat(a, s, ev.msg_type_byte);
            icep_pkg::EV_T304:
            begin
                if (s != icep_pkg::ST_OVLP)
                    a.unexpected = 1'b1;
                else
                begin
                    a = with_release(a, icep_pkg::CAUSE_TIMER);
                    a.indication = icep_pkg::IND_REL;
                end
            end
            icep_pkg::EV_T308:
            begin
                if (s != icep_pkg::ST_RELR)
                    a.unexpected = 1'b1;
                else if (!model_retried)
                begin
                    a.send_msg = icep_pkg::MSG_REL;
                    a.timer_start = a.timer_start | icep_pkg::TM_T308;
                    model_retried = 1'b1;
                end
                else
                begin
                    a.indication = icep_pkg::IND_RELCOMP;
                    a.next_state = icep_pkg::ST_NULL;
                end
            end
            icep_pkg::EV_T322:
            begin
                if (s == icep_pkg::ST_NULL)
                    a.unexpected = 1'b1;
                else if (model_enq_count > model_max_enq)
                begin
                    a = with_release(a, icep_pkg::CAUSE_TEMP_FAIL);
                    a.indication = icep_pkg::IND_REL;
                end
                else
                begin
                    a.send_msg = icep_pkg::MSG_ENQ;
                    a.timer_start = a.timer_start | icep_pkg::TM_T322;
                    if (model_enq_count < icep_pkg::ENQ_COUNT_MAX)
                        model_enq_count = model_enq_count + 3'd1;
                end
            end
            default: ;
        endcase
        newrun = (run & ~a.timer_stop) | a.timer_start;
        if (a.next_state == icep_pkg::ST_NULL)
        begin
            a.timer_stop = a.timer_stop | run | a.timer_start;
            a.timer_start = icep_pkg::TM_NONE;
            newrun = icep_pkg::TM_NONE;
            model_retried = 1'b0;
            model_enq_count = 3'd0;
        end
        model_state = icep_pkg::state_t'(a.next_state);
        model_timers = newrun;
        return a;
    endfunction

    function automatic icep_pkg::in_item_t make_event(logic [4:0] rt, logic ok, logic hcs,
                                                      logic [5:0] csv, logic hc,
                                                      logic [6:0] cv, logic [7:0] mt);
        icep_pkg::in_item_t ev;
        ev.req_type = rt;
        ev.decode_ok = ok;
        ev.has_call_state = hcs;
        ev.call_state_value = csv;
        ev.has_cause = hc;
        ev.cause_value = cv;
        ev.msg_type_byte = mt;
        return ev;
    endfunction

    function automatic icep_pkg::in_item_t random_event();
        icep_pkg::in_item_t ev;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            ev.req_type = 5'($urandom_range(EV_RX_SETUP, EV_UNUSED_HIGH));
        else if (r < 20)
            ev.req_type = icep_pkg::EV_T322;
        else if (r < 32 && model_state == icep_pkg::ST_NULL)
            ev.req_type = 5'($urandom_range(icep_pkg::EV_ALERT_REQ,
                                            icep_pkg::EV_SETUPACK_REQ));
        else if (r < 40)
            ev.req_type = icep_pkg::EV_RX_STATUS;
        else if (r < 46)
            ev.req_type = icep_pkg::EV_T308;
        else
            ev.req_type = 5'($urandom_range(icep_pkg::EV_ALERT_REQ, icep_pkg::EV_T322));
        ev.decode_ok = ($urandom_range(0, 99) < 85);
        ev.has_call_state = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
            0: ev.call_state_value = 6'd0;
            1: ev.call_state_value = state_number(model_state);
            default: ev.call_state_value = 6'($urandom_range(0, 63));
        endcase
        ev.has_cause = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
            0: ev.cause_value = icep_pkg::CAUSE_NOT_IMPL;
            1: ev.cause_value = icep_pkg::CAUSE_RESP_ENQ;
            default: ev.cause_value = 7'($urandom_range(0, 127));
        endcase
        ev.msg_type_byte = 8'($urandom_range(0, 255));
        return ev;
    endfunction

    // valid stays high from one item to the next when no gap is drawn
    task automatic send_event(input icep_pkg::in_item_t ev);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= ev;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        expected_actions.push_back(predict_action(ev));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_enquiries(input logic [2:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        model_max_enq = value;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_directed_events();
        send_event(make_event(icep_pkg::EV_RX_OTHER, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'hff));
        send_event(make_event(icep_pkg::EV_RX_ENQ, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(EV_UNUSED_HIGH, 1'b1, 1'b1, 6'd63, 1'b1, 7'd127, 8'hff));
        send_event(make_event(EV_RX_UNKNOWN, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_T322, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_SETUPACK_REQ, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0,
                              8'h00));
        send_event(make_event(icep_pkg::EV_INFO_REQ, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        // decode failure leaves everything alone
        send_event(make_event(icep_pkg::EV_RX_PROC, 1'b0, 1'b0, 6'd0, 1'b0, 7'd0, 8'h02));
        send_event(make_event(icep_pkg::EV_ENQ_REQ, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        // not implemented cause while enquiring is ignored
        send_event(make_event(icep_pkg::EV_RX_STATUS, 1'b1, 1'b1, 6'd25, 1'b1,
                              icep_pkg::CAUSE_NOT_IMPL, 8'h7d));
        // enquiry retries run out and the call is released
        repeat (5)
            send_event(make_event(icep_pkg::EV_T322, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_RX_STATUS, 1'b1, 1'b1, 6'd63, 1'b0, 7'd0,
                              8'h7d));
        send_event(make_event(icep_pkg::EV_T308, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_T308, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_CONN_REQ, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_RX_STATUS, 1'b1, 1'b1, 6'd7, 1'b1, 7'd127,
                              8'h7d));
        send_event(make_event(icep_pkg::EV_RX_RELCOMP, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0,
                              8'h5a));
        send_event(make_event(icep_pkg::EV_SETUPACK_REQ, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0,
                              8'h00));
        send_event(make_event(icep_pkg::EV_T304, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
        send_event(make_event(icep_pkg::EV_RX_REL, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h4d));
        send_event(make_event(icep_pkg::EV_DL_REL, 1'b1, 1'b0, 6'd0, 1'b0, 7'd0, 8'h00));
    endtask

    task automatic test_input_stall();
        send_gap_max = 0;
        hold_request = 1'b1;
        repeat (40)
            send_event(random_event());
        send_gap_max = GAP_MAX;
    endtask

    task automatic test_random_calls(input logic [2:0] max_enq, input int count,
                                     input int gap_max);
        int sent;
        int burst;
        write_max_enquiries(max_enq);
        send_gap_max = gap_max;
        recv_gap_max = gap_max;
        sent = 0;
        while (sent < count)
        begin
            if (model_state != icep_pkg::ST_NULL && $urandom_range(0, 29) == 0)
            begin
                // run of timer expiries to reach the enquiry limit
                burst = $urandom_range(1, 10);
                repeat (burst)
                    send_event(make_event(icep_pkg::EV_T322, 1'b1, 1'b0, 6'd0, 1'b0,
                                          7'd0, 8'h00));
                sent += burst;
            end
            else
            begin
                send_event(random_event());
                sent++;
            end
        end
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
                stall = $urandom_range(0, recv_gap_max);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
        end
    end

    task automatic compare_field(input string name, input logic [7:0] exp,
                                 input logic [7:0] got);
        if (got !== exp)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        icep_pkg::out_item_t exp;
        icep_pkg::out_item_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got = out_ch.data;
            if (expected_actions.size() == 0)
            begin
                $display("%0t: unexpected action item %h", $time, got);
                errors++;
            end
            else
            begin
                exp = expected_actions.pop_front();
                compare_field("next_state", 8'(exp.next_state), 8'(got.next_state));
                compare_field("send_msg", 8'(exp.send_msg), 8'(got.send_msg));
                compare_field("send_cause", 8'(exp.send_cause), 8'(got.send_cause));
                compare_field("diag_byte", exp.diag_byte, got.diag_byte);
                compare_field("reported_state", 8'(exp.reported_state),
                              8'(got.reported_state));
                compare_field("indication", 8'(exp.indication), 8'(got.indication));
                compare_field("timer_start", 8'(exp.timer_start), 8'(got.timer_start));
                compare_field("timer_stop", 8'(exp.timer_stop), 8'(got.timer_stop));
                compare_field("unexpected", 8'(exp.unexpected), 8'(got.unexpected));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
        hold_request = 1'b0;
        model_state = icep_pkg::ST_NULL;
        model_timers = icep_pkg::TM_NONE;
        model_retried = 1'b0;
        model_enq_count = 3'd0;
        model_max_enq = icep_pkg::MAX_ENQ_RESET;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_events();
        test_input_stall();
        test_random_calls(3'd7, 500, GAP_MAX);
        test_random_calls(3'd0, 500, GAP_MAX);
        test_random_calls(3'($urandom_range(1, 6)), 450, GAP_MAX);
        test_random_calls(icep_pkg::MAX_ENQ_RESET, 435, 0);

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
